// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BPFA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BPFA_ASSERT(lbl, clk, rst_n, prop)
`define BPFA_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared codes, field widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package bpfa_pkg;

  localparam int PAGE_W = 12;
  localparam int NUM_W  = 13;

  typedef logic [1:0] func_t;
  localparam func_t FUNC_ALLOC_ANY = 2'd0;
  localparam func_t FUNC_ALLOC_AT  = 2'd1;
  localparam func_t FUNC_FREE      = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t STS_OK   = 2'd0;
  localparam status_t STS_OOM  = 2'd1;
  localparam status_t STS_USED = 2'd2;

  localparam logic [7:0]       ALL_USED_BYTE   = 8'hFF;
  localparam logic [NUM_W-1:0] TOTAL_PAGES_RST = 13'd4096;

  typedef struct packed {
    logic init;      // clearing sweep step
    logic accept;    // latch new item
    logic scan;      // first-fit scan running
    logic load;      // set up mark/free range
    logic mark;      // read-modify-write over range
    logic load_out;  // fill output register
  } cmd_t;

  typedef struct packed {
    logic init_done;
    logic scan_done;
    logic scan_hit;
    logic mark_done;
    logic out_full;
  } sts_t;

endpackage

// File: rtl/bpfa_if.sv
// ----------------------------------------------------------------------------
// bpfa_if
// Valid/ready channels: request, response and configuration write.
// ----------------------------------------------------------------------------
interface bpfa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] start_page;
  logic [12:0] num_pages;
  modport source (output valid, func, start_page, num_pages, input ready);
  modport sink   (input valid, func, start_page, num_pages, output ready);
endinterface

interface bpfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] found_page;
  logic [1:0]  status;
  logic [12:0] used_pages;
  modport source (output valid, found_page, status, used_pages, input ready);
  modport sink   (input valid, found_page, status, used_pages, output ready);
endinterface

interface bpfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] total_pages;
  modport source (output valid, total_pages, input ready);
  modport sink   (input valid, total_pages, output ready);
endinterface

// File: rtl/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// First-fit page frame allocator over a one-bit-per-page used map.
//
// req_if carries one item: func (0 allocate anywhere, 1 allocate at
// start_page, 2 free range), start_page and num_pages. rsp_if returns one
// item per request: found_page, status (ok / out of memory / already used)
// and the used page count after the operation. cfg_if writes total_pages,
// always ready; write it only while no item is in flight.
// The map is a RAM of ceil(NUM_PAGES/8) bytes, processed one byte per
// cycle. After reset a clearing sweep marks every page used; requests
// are held off until it ends.
// Allocate-anywhere runs accept, scan, range setup, mark and result;
// allocate-at and free run accept, range setup, mark and result. A scan
// that finds nothing goes straight to the result. One item at a time.
// The result sits in an output register: a new item is taken while it
// waits, but that item's result waits until the old one is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_page_frame_allocator #(
  parameter int NUM_PAGES = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bpfa_req_if.sink          req_if,
  bpfa_rsp_if.source        rsp_if,
  bpfa_cfg_if.sink          cfg_if
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;
  logic           req_ready;

  assign req_if.ready = req_ready;
  assign cfg_if.ready = 1'b1;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_if.valid),
    .req_func_i  (req_if.func),
    .req_ready_o (req_ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bpfa_datapath #(.NUM_PAGES(NUM_PAGES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .req_func_i   (req_if.func),
    .req_start_i  (req_if.start_page),
    .req_num_i    (req_if.num_pages),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_data_i   (cfg_if.total_pages),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_valid_o  (rsp_if.valid),
    .rsp_found_o  (rsp_if.found_page),
    .rsp_status_o (rsp_if.status),
    .rsp_used_o   (rsp_if.used_pages)
  );

  `BPFA_ASSERT(a_one_at_a_time, clk_i, rst_ni, (req_if.valid && req_ready) |=> !req_ready)
  `BPFA_ASSERT(a_oom_zero, clk_i, rst_ni, (rsp_if.valid && rsp_if.status == bpfa_pkg::STS_OOM) |-> (rsp_if.found_page == 12'd0))
  `BPFA_ASSERT_NEVER(a_single_cmd, clk_i, rst_ni, !$onehot0({cmd.init, cmd.accept, cmd.scan, cmd.load, cmd.mark, cmd.load_out}))

endmodule

// File: rtl/bpfa_ram.sv
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/bpfa_datapath.sv
// ----------------------------------------------------------------------------
// bpfa_datapath
// Byte-wide page bitmap, first-fit scan, range mark/free and output register.
// ----------------------------------------------------------------------------
module bpfa_datapath #(
  parameter int NUM_PAGES = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bpfa_pkg::cmd_t         cmd_i,
  output bpfa_pkg::sts_t         sts_o,
  input  bpfa_pkg::func_t        req_func_i,
  input  logic [11:0]            req_start_i,
  input  logic [12:0]            req_num_i,
  input  logic                   cfg_valid_i,
  input  logic [12:0]            cfg_data_i,
  input  logic                   rsp_ready_i,
  output logic                   rsp_valid_o,
  output logic [11:0]            rsp_found_o,
  output bpfa_pkg::status_t      rsp_status_o,
  output logic [12:0]            rsp_used_o
);

  localparam int NB = (NUM_PAGES + 7) / 8;
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int PW = $clog2(NUM_PAGES);
  localparam int CW = $clog2(NUM_PAGES + 1);
  localparam int EW = ((PW > bpfa_pkg::NUM_W) ? PW : bpfa_pkg::NUM_W) + 1;
  localparam int XW = BW + 3;
  localparam logic [EW-1:0] NP      = EW'(NUM_PAGES);
  localparam logic [BW-1:0] LAST_B  = BW'(NB - 1);

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int i = 0; i < 8; i++) begin
      c = c + {3'd0, v[i]};
    end
    return c;
  endfunction

  bpfa_pkg::func_t func_q;
  logic [11:0]     start_q;
  logic [12:0]     num_q;
  logic [12:0]     total_q;
  logic [BW-1:0]   rp_q, rp_end_q, fb_q, db_q, ic_q;
  logic            rd_act_q, dv_q;
  logic [12:0]     run_q;
  logic            hit_q;
  logic [PW-1:0]   at_q;
  logic [EW-1:0]   first_q, endc_q;
  logic [CW-1:0]   cnt_q;
  logic            clash_q;
  logic            out_vld_q;
  logic [11:0]     out_found_q;
  bpfa_pkg::status_t out_sts_q;
  logic [12:0]     out_used_q;

  logic [7:0]      rd_data;
  logic [EW-1:0]   lim, lim_m1, first_n, end_n, endc_n, last_n, last_q;
  logic [BW-1:0]   scan_last;
  logic            en;

  // search limit = min(total_pages, NUM_PAGES)
  assign lim       = (EW'(total_q) < NP) ? EW'(total_q) : NP;
  assign lim_m1    = lim - EW'(1);
  assign scan_last = lim_m1[BW+2:3];

  assign first_n = (func_q == bpfa_pkg::FUNC_ALLOC_ANY) ? EW'(at_q) : EW'(start_q);
  assign end_n   = first_n + EW'(num_q);
  assign endc_n  = (end_n < NP) ? end_n : NP;
  assign last_n  = endc_n - EW'(1);
  assign last_q  = endc_q - EW'(1);

  assign en = cmd_i.scan | cmd_i.mark;

  // scan of one byte, bits in ascending page order
  logic [12:0]   r;
  logic          h;
  logic [2:0]    hp;
  logic [XW-1:0] hit_pg;
  logic [EW-1:0] at_full;
  logic [PW-1:0] at_now;

  always_comb begin
    r  = run_q;
    h  = 1'b0;
    hp = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (!h && (EW'({db_q, 3'(k)}) < lim)) begin
        if (rd_data[k]) begin
          r = 13'd0;
        end else begin
          r = r + 13'd1;
          if (r == num_q) begin
            h  = 1'b1;
            hp = 3'(k);
          end
        end
      end
    end
  end

  assign hit_pg  = {db_q, hp};
  assign at_full = EW'(hit_pg) + EW'(1) - EW'(num_q);
  assign at_now  = (num_q == 13'd0) ? '0 : at_full[PW-1:0];

  // mark/free of one byte
  logic [2:0] lo, hi;
  logic [7:0] mask, set_bits, clr_bits, new_byte;
  logic       is_free, mark_empty;

  assign is_free    = (func_q == bpfa_pkg::FUNC_FREE);
  assign mark_empty = !(endc_q > first_q);
  assign lo = (db_q == fb_q) ? first_q[2:0] : 3'd0;
  assign hi = (db_q == rp_end_q) ? last_q[2:0] : 3'd7;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      mask[k] = (3'(k) >= lo) && (3'(k) <= hi);
    end
  end

  assign set_bits = mask & ~rd_data;
  assign clr_bits = mask & rd_data;
  assign new_byte = is_free ? (rd_data & ~mask) : (rd_data | mask);

  always_comb begin
    sts_o.init_done = (ic_q == LAST_B);
    sts_o.scan_hit  = (num_q == 13'd0) ? (lim != '0) : (dv_q && h);
    sts_o.scan_done = (num_q == 13'd0) || (lim == '0) ||
                      (dv_q && (h || (db_q == rp_end_q)));
    sts_o.mark_done = mark_empty || (dv_q && (db_q == rp_end_q));
    sts_o.out_full  = out_vld_q && !rsp_ready_i;
  end

  bpfa_ram #(.WIDTH(8), .DEPTH(NB)) u_map (
    .clk_i   (clk_i),
    .we_i    (cmd_i.init | (cmd_i.mark & dv_q)),
    .waddr_i (cmd_i.init ? ic_q : db_q),
    .wdata_i (cmd_i.init ? bpfa_pkg::ALL_USED_BYTE : new_byte),
    .raddr_i (rp_q),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= bpfa_pkg::TOTAL_PAGES_RST;
      cnt_q     <= CW'(NUM_PAGES);
      ic_q      <= '0;
      rd_act_q  <= 1'b0;
      dv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (cmd_i.init && !sts_o.init_done) begin
        ic_q <= ic_q + BW'(1);
      end
      dv_q <= en & rd_act_q;
      if (en && rd_act_q) begin
        rp_q     <= rp_q + BW'(1);
        // reads stop at the last byte or once the scan has its answer
        rd_act_q <= (rp_q != rp_end_q) && !(cmd_i.scan && sts_o.scan_done);
        db_q     <= rp_q;
      end
      if (cmd_i.accept) begin
        func_q   <= req_func_i;
        start_q  <= req_start_i;
        num_q    <= req_num_i;
        rp_q     <= '0;
        rp_end_q <= scan_last;
        run_q    <= 13'd0;
        clash_q  <= 1'b0;
        hit_q    <= 1'b0;
        rd_act_q <= (req_func_i == bpfa_pkg::FUNC_ALLOC_ANY) && (lim != '0) &&
                    (req_num_i != 13'd0);
      end
      if (cmd_i.scan) begin
        if (dv_q) begin
          run_q <= r;
        end
        if (sts_o.scan_done) begin
          hit_q    <= sts_o.scan_hit;
          at_q     <= at_now;
        end
      end
      if (cmd_i.load) begin
        first_q  <= first_n;
        endc_q   <= endc_n;
        rp_q     <= first_n[BW+2:3];
        fb_q     <= first_n[BW+2:3];
        rp_end_q <= last_n[BW+2:3];
        rd_act_q <= (endc_n > first_n);
      end
      if (cmd_i.mark && dv_q) begin
        if (is_free) begin
          cnt_q <= cnt_q - CW'(pop8(clr_bits));
        end else begin
          cnt_q   <= cnt_q + CW'(pop8(set_bits));
          clash_q <= clash_q | (|clr_bits);
        end
      end
      if (cmd_i.load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_used_q <= 13'(cnt_q);
      case (func_q)
        bpfa_pkg::FUNC_ALLOC_ANY: begin
          out_found_q <= hit_q ? 12'(at_q) : 12'd0;
          out_sts_q   <= hit_q ? bpfa_pkg::STS_OK : bpfa_pkg::STS_OOM;
        end
        bpfa_pkg::FUNC_ALLOC_AT: begin
          out_found_q <= start_q;
          out_sts_q   <= clash_q ? bpfa_pkg::STS_USED : bpfa_pkg::STS_OK;
        end
        default: begin
          out_found_q <= start_q;
          out_sts_q   <= bpfa_pkg::STS_OK;
        end
      endcase
    end
  end

  assign rsp_valid_o  = out_vld_q;
  assign rsp_found_o  = out_found_q;
  assign rsp_status_o = out_sts_q;
  assign rsp_used_o   = out_used_q;

endmodule

// File: rtl/bpfa_ctrl.sv
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Sequencer: clearing sweep, accept, scan, range setup, mark, result.
// ----------------------------------------------------------------------------
module bpfa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  bpfa_pkg::func_t req_func_i,
  output logic            req_ready_o,
  output bpfa_pkg::cmd_t  cmd_o,
  input  bpfa_pkg::sts_t  sts_i
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_LOAD, S_MARK, S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        cmd_o.init = 1'b1;
        if (sts_i.init_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          case (req_func_i)
            bpfa_pkg::FUNC_ALLOC_ANY: state_d = S_SCAN;
            bpfa_pkg::FUNC_ALLOC_AT:  state_d = S_LOAD;
            bpfa_pkg::FUNC_FREE:      state_d = S_LOAD;
            default:                  state_d = S_FIN;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) state_d = sts_i.scan_hit ? S_LOAD : S_FIN;
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (sts_i.mark_done) state_d = S_FIN;
      end
      S_FIN: begin
        // wait here only while the previous result is still held
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

endmodule
